@@ hw/rtl/assert_macros.svh @@
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/wrms_pkg.sv @@
package wrms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int ACC_BITS    = 47;
  localparam int CNT_BITS    = 16;
  localparam int OUT_BITS    = 24;

  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  // dividend is the sum scaled by 2^(2*FRAC_BITS)
  localparam int DIVD_BITS = ACC_BITS + 2 * FRAC_BITS;
  localparam int DIV_BITS  = CNT_BITS + 1;
  localparam int DREM_BITS = CNT_BITS;
  localparam int SREM_BITS = OUT_BITS + 1;
  localparam int STEP_BITS = 6;

  localparam int ADDR_BITS = 3;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CNT_BITS-1:0] WINDOW_RESET = 16'd1600;

  // largest level: a full window of most negative samples
  localparam logic [OUT_BITS-1:0] LEVEL_MAX = 24'h800000;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

@@ hw/rtl/windowed_rms_level_meter.sv @@
// Channel   Dir   Handshake                     Payload
// in        in    in_tvalid / in_tready         in_tdata[15:0]  sample
// out       out   out_tvalid / out_tready       out_tdata[23:0] rms_level
// cfg       in    APB, pready tied high         window_length at byte 0
//
// A sample is accepted, then squared by 16 shift-add steps of the squarer.
// The sample that closes a window adds 63 divider steps (one quotient bit each),
// 24 root steps (one root bit each) and a final load of the output register.
// rst_n is synchronous: clears sum, count, state and output valid; window 1600.
// A result waiting in the output register does not block new samples; a second
// result stalls in the final state until the first transfer completes.
module windowed_rms_level_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wrms_pkg::SAMPLE_BITS-1:0]  in_tdata,    // [15:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wrms_pkg::OUT_BITS-1:0]     out_tdata,   // [23:0] rms_level
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wrms_pkg::ADDR_BITS-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SB = wrms_pkg::SAMPLE_BITS;
  localparam int PB = wrms_pkg::PROD_BITS;
  localparam int AB = wrms_pkg::ACC_BITS;
  localparam int CB = wrms_pkg::CNT_BITS;
  localparam int OB = wrms_pkg::OUT_BITS;
  localparam int DB = wrms_pkg::DIVD_BITS;
  localparam int VB = wrms_pkg::DIV_BITS;
  localparam int RB = wrms_pkg::DREM_BITS;
  localparam int QB = wrms_pkg::SREM_BITS;
  localparam int TB = wrms_pkg::STEP_BITS;
  localparam int FB2 = 2 * wrms_pkg::FRAC_BITS;

  wrms_pkg::state_t state_r, state_nxt;

  logic [CB-1:0] window_r;
  logic [AB-1:0] acc_r, acc_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [PB-1:0] mcand_r, mcand_nxt;
  logic [SB-1:0] mplier_r, mplier_nxt;
  logic [TB-1:0] step_r, step_nxt;
  logic [VB-1:0] div_r, div_nxt;
  logic [RB-1:0] drem_r, drem_nxt;
  logic [DB-1:0] dq_r, dq_nxt;
  logic [QB-1:0] srem_r, srem_nxt;
  logic [OB-1:0] root_r, root_nxt;
  logic [OB-1:0] out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          cfg_wr;
  logic [SB-1:0] mag;
  logic [AB-1:0] acc_sum;
  logic [VB-1:0] taken, limit;
  logic [VB-1:0] dtrial;
  logic          dge;
  logic [QB:0]   strial_r2, strial;
  logic          sge;
  logic          out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                  (cfg_paddr[2] == wrms_pkg::REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == wrms_pkg::REG_WINDOW_LENGTH) ?
                      {{(32-CB){1'b0}}, window_r} : 32'd0;

  assign in_tready  = (state_r == wrms_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = ~out_valid_r | out_tready;

  // two's complement magnitude; the most negative sample maps to 2^(SB-1)
  assign mag = in_tdata[SB-1] ? (~in_tdata + 1'b1) : in_tdata;

  assign acc_sum = acc_r + (mplier_r[0] ? {{(AB-PB){1'b0}}, mcand_r} : '0);
  assign taken   = {1'b0, cnt_r} + 1'b1;
  // a zero window length means 2^CB samples
  assign limit   = (window_r == '0) ? {1'b1, {CB{1'b0}}} : {1'b0, window_r};

  // restoring division, one quotient bit per step
  assign dtrial = {drem_r, dq_r[DB-1]};
  assign dge    = (dtrial >= div_r);

  // restoring square root, one root bit per step, two radicand bits consumed
  assign strial_r2 = {srem_r[QB-2:0], dq_r[2*OB-1 -: 2]};
  assign strial    = {root_r, 2'b01};
  assign sge       = (strial_r2 >= strial);

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    step_nxt      = step_r;
    div_nxt       = div_r;
    drem_nxt      = drem_r;
    dq_nxt        = dq_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      wrms_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mcand_nxt  = {{(PB-SB){1'b0}}, mag};
          mplier_nxt = mag;
          step_nxt   = TB'(SB - 1);
          state_nxt  = wrms_pkg::ST_MAC;
        end
      end
      wrms_pkg::ST_MAC: begin
        acc_nxt    = acc_sum;
        mcand_nxt  = {mcand_r[PB-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[SB-1:1]};
        step_nxt   = step_r - 1'b1;
        if (step_r == '0) begin
          if (taken < limit) begin
            cnt_nxt   = taken[CB-1:0];
            state_nxt = wrms_pkg::ST_IDLE;
          end else begin
            dq_nxt    = {acc_sum, {FB2{1'b0}}};
            div_nxt   = taken;
            drem_nxt  = '0;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            step_nxt  = TB'(DB - 1);
            state_nxt = wrms_pkg::ST_DIV;
          end
        end
      end
      wrms_pkg::ST_DIV: begin
        drem_nxt = dge ? RB'(dtrial - div_r) : dtrial[RB-1:0];
        dq_nxt   = {dq_r[DB-2:0], dge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = TB'(OB - 1);
          state_nxt = wrms_pkg::ST_SQRT;
        end
      end
      wrms_pkg::ST_SQRT: begin
        srem_nxt = sge ? QB'(strial_r2 - strial) : strial_r2[QB-1:0];
        root_nxt = {root_r[OB-2:0], sge};
        dq_nxt   = {dq_r[DB-3:0], 2'b00};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = wrms_pkg::ST_FIN;
        end
      end
      wrms_pkg::ST_FIN: begin
        if (out_free) begin
          out_data_nxt  = root_r;
          out_valid_nxt = 1'b1;
          state_nxt     = wrms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wrms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrms_pkg::ST_IDLE;
      window_r    <= wrms_pkg::WINDOW_RESET;
      acc_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        window_r <= cfg_pwdata[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    div_r      <= div_nxt;
    drem_r     <= drem_nxt;
    dq_r       <= dq_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hw/rtl/wrms_chk.sv @@
`include "assert_macros.svh"

module wrms_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wrms_pkg::OUT_BITS-1:0]    out_tdata,
  input logic                             cfg_pready
);

  // a stalled level stays put
  `ASSERT_RUN(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "level changed while stalled")

  `ASSERT_RUN(a_level_range, clk, rst_n, out_tvalid |-> out_tdata <= wrms_pkg::LEVEL_MAX, "level above full scale")

  // squarer is busy after every transfer in
  `ASSERT_RUN(a_busy_after_in, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "sample taken while squaring")

  // no level can come out of the first cycle after reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "level valid after reset")

  `ASSERT_ALWAYS(a_pready_high, clk, cfg_pready, "cfg ready dropped")

endmodule

bind windowed_rms_level_meter wrms_chk u_wrms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SETTLE_CYCLES  = 128;   // longest sample: squarer, divider, root and output load
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_SAMPLES = 1300;
  localparam int unsigned IDLE_MAX       = 16;

  localparam int AB = wrms_pkg::ADDR_BITS;
  localparam int SB = wrms_pkg::SAMPLE_BITS;
  localparam int OB = wrms_pkg::OUT_BITS;
  localparam int XB = wrms_pkg::ACC_BITS;
  localparam int CB = wrms_pkg::CNT_BITS;

  localparam logic [AB-1:0] WINDOW_ADDR = AB'(4 * int'(wrms_pkg::REG_WINDOW_LENGTH));
  localparam logic [AB-1:0] SPARE_ADDR  = AB'(4 * (int'(wrms_pkg::REG_WINDOW_LENGTH) + 1));

  localparam logic [SB-1:0] SAMPLE_MIN  = 16'h8000;
  localparam logic [SB-1:0] SAMPLE_MAX  = 16'h7fff;
  localparam logic [SB-1:0] SAMPLE_ZERO = 16'h0000;
  localparam logic [SB-1:0] SAMPLE_NEG1 = 16'hffff;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SB-1:0]          in_tdata;     // [15:0] sample
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OB-1:0]          out_tdata;    // [23:0] rms_level
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [AB-1:0]          cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  windowed_rms_level_meter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [XB-1:0] sum_squares;
  logic [CB-1:0] samples_in_window;
  logic [CB-1:0] window_len;
  logic [OB-1:0] expected_levels[$];

  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned n_samples;
  int unsigned n_levels;
  int unsigned n_cfg_writes;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  logic [OB-1:0] want_level;

  // floor(sqrt(floor(sum * 2^16 / n)))
  function automatic logic [OB-1:0] window_rms(input logic [XB-1:0] sum,
                                               input logic [CB:0] n);
    logic [63:0] mean;
    logic [31:0] root;
    logic [31:0] cand;
    logic [63:0] sq;
    mean = {1'b0, sum, 16'b0} / {47'b0, n};
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (32'd1 << b);
      sq = {32'b0, cand} * {32'b0, cand};
      if (sq <= mean) root = cand;
    end
    return root[OB-1:0];
  endfunction

  task automatic accumulate_sample(input logic [SB-1:0] s);
    logic [SB:0] mag;
    logic [CB:0] taken;
    logic [CB:0] limit;
    mag = s[SB-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    sum_squares = sum_squares + mag * mag;
    taken = {1'b0, samples_in_window} + 17'd1;
    limit = (window_len == '0) ? 17'h10000 : {1'b0, window_len};
    if (taken < limit) begin
      samples_in_window = taken[CB-1:0];
    end else begin
      expected_levels.push_back(window_rms(sum_squares, taken));
      sum_squares = '0;
      samples_in_window = '0;
    end
  endtask

  // called and returns on a falling edge
  task automatic send_sample(input logic [SB-1:0] s);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    accumulate_sample(s);
    n_samples++;
    @(negedge clk);
  endtask

  // no write until the block has finished the last sample it took
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [AB-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr / 4 == wrms_pkg::REG_WINDOW_LENGTH) window_len = data[CB-1:0];
    n_cfg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_window_reg();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= WINDOW_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'b0, window_len}) begin
      $display("%0t: window_length readback: expected %0d, actual %0d",
               $time, window_len, cfg_prdata);
      n_errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return SAMPLE_ZERO;
      3:       return SAMPLE_NEG1;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic test_register_access();
    check_window_reg();
    cfg_write(SPARE_ADDR, 32'hffff_ffff);   // no such register
    check_window_reg();
  endtask

  // window of one: level is |sample| << 8
  task automatic test_single_sample_windows();
    cfg_write(WINDOW_ADDR, 32'd1);
    check_window_reg();
    send_sample(SAMPLE_ZERO);
    send_sample(16'h0001);
    send_sample(SAMPLE_NEG1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    settle();
  endtask

  task automatic test_three_sample_windows();
    cfg_write(WINDOW_ADDR, 32'd3);
    send_sample(16'd100);
    send_sample(-16'sd200);
    send_sample(16'd300);
    repeat (3) send_sample(SAMPLE_MIN);     // full-scale level
    settle();
  endtask

  // count kept across writes; a shorter window closes on the next sample
  task automatic test_window_resize();
    cfg_write(WINDOW_ADDR, 32'd65535);
    check_window_reg();
    repeat (4) send_sample(pick_sample());
    settle();
    cfg_write(WINDOW_ADDR, 32'd2);
    send_sample(16'd1234);
    settle();
    cfg_write(WINDOW_ADDR, 32'd65535);
    repeat (3) send_sample(pick_sample());
    settle();
    cfg_write(WINDOW_ADDR, 32'd6);
    repeat (3) send_sample(pick_sample());
    settle();
  endtask

  task automatic test_random_windows();
    int unsigned sent;
    int unsigned burst;
    logic [CB-1:0] w;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 15))
        0:       w = 16'd1;
        1:       w = 16'd65535;
        2:       w = 16'd0;
        3, 4:    w = CB'($urandom_range(9, 64));
        default: w = CB'($urandom_range(2, 8));
      endcase
      cfg_write(WINDOW_ADDR, {16'b0, w});
      if ($urandom_range(0, 3) == 0) cfg_write(SPARE_ADDR, $urandom);
      check_window_reg();
      in_gap_max    = $urandom_range(0, 1) ? IDLE_MAX : 0;
      out_stall_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
      burst = $urandom_range(1, 48);
      repeat (burst) send_sample(pick_sample());
      sent += burst;
      settle();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: rms_level: expected none, actual %0d", $time, out_tdata);
        n_errors++;
      end else begin
        want_level = expected_levels.pop_front();
        n_levels++;
        if (out_tdata !== want_level) begin
          $display("%0t: rms_level: expected %0d, actual %0d", $time, want_level, out_tdata);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d levels outstanding",
               $time, quiet_cycles, expected_levels.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    sum_squares       = '0;
    samples_in_window = '0;
    window_len        = wrms_pkg::WINDOW_RESET;
    in_gap_max    = IDLE_MAX;
    out_stall_max = IDLE_MAX;
    n_samples     = 0;
    n_levels      = 0;
    n_cfg_writes  = 0;
    n_errors      = 0;
    quiet_cycles  = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_single_sample_windows();
    test_three_sample_windows();
    test_window_resize();
    test_random_windows();
    settle();

    $display("Covered %0d samples and %0d RMS levels over %0d register writes,",
             n_samples, n_levels, n_cfg_writes);
    $display("short, long and zero window settings, mid-window resizing and random stalls.");
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
